### rtl/fsgr_pkg.sv
// Package for the font strike glyph row renderer.
// Holds shared types, item codes and fixed field widths.
// No dependencies.
package fsgr_pkg;

  // Width of the shared adder: wide enough for any strike byte address
  localparam int ALU_W = 17;

  // Input item kinds
  localparam logic [1:0] KIND_STRIKE = 2'd0;
  localparam logic [1:0] KIND_OFFSET = 2'd1;
  localparam logic [1:0] KIND_DRAW   = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_FIRST_CODE   = 3'd0;
  localparam logic [2:0] REG_LAST_CODE    = 3'd1;
  localparam logic [2:0] REG_ROW_STRIDE   = 3'd2;
  localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd3;
  localparam logic [2:0] REG_SCALE_X      = 3'd4;
  localparam logic [2:0] REG_SCALE_Y      = 3'd5;

  // Configuration register file contents
  typedef struct packed {
    logic [12:0] first_code;
    logic [12:0] last_code;
    logic [10:0] row_stride;
    logic [5:0]  glyph_height;
    logic [6:0]  scale_x;
    logic [6:0]  scale_y;
  } cfg_t;

  // Request to the shared adder: a + b, or a - b when sub is set
  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

  // Adder answer; carry set on subtract means a >= b
  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             carry;
  } alu_rsp_t;

endpackage

### rtl/fsgr_ram.sv
// Generic simple dual-port RAM with registered read.
// One write port and one read port; no dependencies.
module fsgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/fsgr_alu.sv
// Shared add/subtract unit used by the glyph sequencer for its address and coordinate sums and code range compares.
// Depends on fsgr_pkg.
module fsgr_alu
  import fsgr_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [ALU_W:0] full;

  // Add, or add the complement plus one for subtract
  always_comb begin
    full = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)} + {{ALU_W{1'b0}}, req.sub};
    rsp.sum   = full[ALU_W-1:0];
    rsp.carry = full[ALU_W];
  end

endmodule

### rtl/fsgr_cfg.sv
// Configuration register file behind the APB-style port.
// Depends on fsgr_pkg; presents all registers as one cfg_t.
module fsgr_cfg
  import fsgr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  // Decode writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_FIRST_CODE:   cfg_nxt.first_code   = pwdata[12:0];
        REG_LAST_CODE:    cfg_nxt.last_code    = pwdata[12:0];
        REG_ROW_STRIDE:   cfg_nxt.row_stride   = pwdata[10:0];
        REG_GLYPH_HEIGHT: cfg_nxt.glyph_height = pwdata[5:0];
        REG_SCALE_X:      cfg_nxt.scale_x      = pwdata[6:0];
        REG_SCALE_Y:      cfg_nxt.scale_y      = pwdata[6:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      REG_FIRST_CODE:   prdata = {19'd0, cfg_r.first_code};
      REG_LAST_CODE:    prdata = {19'd0, cfg_r.last_code};
      REG_ROW_STRIDE:   prdata = {21'd0, cfg_r.row_stride};
      REG_GLYPH_HEIGHT: prdata = {26'd0, cfg_r.glyph_height};
      REG_SCALE_X:      prdata = {25'd0, cfg_r.scale_x};
      REG_SCALE_Y:      prdata = {25'd0, cfg_r.scale_y};
      default:          prdata = 32'd0;
    endcase
  end

  // Hold registers, load reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_code   <= 13'd0;
      cfg_r.last_code    <= 13'd255;
      cfg_r.row_stride   <= 11'd256;
      cfg_r.glyph_height <= 6'd16;
      cfg_r.scale_x      <= 7'd3;
      cfg_r.scale_y      <= 7'd3;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/fsgr_core.sv
// Glyph sequencer: takes items, loads the stores, walks glyph rows through the
// shared adder and drives the result register. Depends on fsgr_pkg, fsgr_alu.
module fsgr_core
  import fsgr_pkg::*;
#(
  parameter int STRIKE_BYTES   = 16384,
  parameter int OFFSET_ENTRIES = 512,
  parameter int MAX_WIDTH      = 32,
  parameter int MAX_HEIGHT     = 32,
  localparam int SAW = $clog2(STRIKE_BYTES),
  localparam int OAW = $clog2(OFFSET_ENTRIES)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  // input item channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic [13:0]        in_load_address,
  input  logic [15:0]        in_load_value,
  input  logic [12:0]        in_char_code,
  input  logic signed [15:0] in_x_origin,
  input  logic signed [15:0] in_y_origin,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         out_row_index,
  output logic signed [15:0] out_row_top,
  output logic signed [15:0] out_row_bottom,
  output logic signed [15:0] out_x_left,
  output logic [31:0]        out_pixel_mask,
  output logic [5:0]         out_glyph_width,
  output logic               out_last_row,
  // strike store
  output logic               st_we,
  output logic [SAW-1:0]     st_waddr,
  output logic [7:0]         st_wdata,
  output logic [SAW-1:0]     st_raddr,
  input  logic [7:0]         st_rdata,
  // offset store
  output logic               of_we,
  output logic [OAW-1:0]     of_waddr,
  output logic [15:0]        of_wdata,
  output logic [OAW-1:0]     of_raddr,
  input  logic [15:0]        of_rdata
);

  localparam int MAXW_SAT = (MAX_WIDTH > 64) ? 64 : MAX_WIDTH;
  localparam int HCAP     = (MAX_HEIGHT > 32) ? 32 : MAX_HEIGHT;
  localparam logic [ALU_W-1:0] STRIKE_LIM = ALU_W'(STRIKE_BYTES);
  localparam logic [13:0]      OFS_LIM    = 14'(OFFSET_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE, S_CHK_LO, S_CHK_HI, S_OFS0, S_OFS1, S_OFS2,
    S_WID, S_SETUP, S_BYTE, S_WAIT, S_BOT, S_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  logic [12:0]        code_r, code_nxt;
  logic [15:0]        x_r, x_nxt;
  logic [15:0]        top_r, top_nxt;
  logic [15:0]        tnext_r, tnext_nxt;
  logic [15:0]        bot_r, bot_nxt;
  logic [13:0]        idx_r, idx_nxt;
  logic               oor_r, oor_nxt;
  logic [15:0]        start_r, start_nxt;
  logic [15:0]        next_r, next_nxt;
  logic [6:0]         width_r, width_nxt;
  logic [2:0]         nbytes_r, nbytes_nxt;
  logic [5:0]         height_r, height_nxt;
  logic [4:0]         row_r, row_nxt;
  logic [ALU_W-1:0]   rowaddr_r, rowaddr_nxt;
  logic [2:0]         k_r, k_nxt;
  logic               pend_r, pend_nxt;
  logic [2:0]         pend_k_r, pend_k_nxt;
  logic               pend_oob_r, pend_oob_nxt;
  logic [39:0]        win_r, win_nxt;
  logic               ov_r, ov_nxt;
  logic [4:0]         o_row_r, o_row_nxt;
  logic [15:0]        o_top_r, o_top_nxt;
  logic [15:0]        o_bot_r, o_bot_nxt;
  logic [15:0]        o_x_r, o_x_nxt;
  logic [31:0]        o_mask_r, o_mask_nxt;
  logic [5:0]         o_width_r, o_width_nxt;
  logic               o_last_r, o_last_nxt;

  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;
  logic               in_acc;
  logic               out_free;
  logic [39:0]        win_sh;
  logic [31:0]        mask_c;
  logic [5:0]         rd_w;
  logic [6:0]         nsum;
  logic               last_c;
  logic [7:0]         byte_c;

  fsgr_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Handshake and store writes
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !ov_r || !out_stall;

  assign st_we    = in_acc && (in_kind == KIND_STRIKE) && (ALU_W'(in_load_address) < STRIKE_LIM);
  assign st_waddr = SAW'(in_load_address);
  assign st_wdata = in_load_value[7:0];
  assign st_raddr = SAW'(alu_rsp.sum);

  assign of_we    = in_acc && (in_kind == KIND_OFFSET) && (in_load_address < OFS_LIM);
  assign of_waddr = OAW'(in_load_address);
  assign of_wdata = in_load_value;
  assign of_raddr = OAW'(idx_r);

  assign out_valid       = ov_r;
  assign out_row_index   = o_row_r;
  assign out_row_top     = o_top_r;
  assign out_row_bottom  = o_bot_r;
  assign out_x_left      = o_x_r;
  assign out_pixel_mask  = o_mask_r;
  assign out_glyph_width = o_width_r;
  assign out_last_row    = o_last_r;

  // Select adder operands for the current step
  always_comb begin
    alu_req = '0;
    case (state_r)
      S_CHK_LO: begin
        alu_req.a   = ALU_W'(code_r);
        alu_req.b   = ALU_W'(cfg.first_code);
        alu_req.sub = 1'b1;
      end
      S_CHK_HI: begin
        alu_req.a   = ALU_W'(cfg.last_code);
        alu_req.b   = ALU_W'(code_r);
        alu_req.sub = 1'b1;
      end
      S_OFS0: begin
        alu_req.a = ALU_W'(idx_r);
        alu_req.b = ALU_W'(1'b1);
      end
      S_WID: begin
        alu_req.a   = ALU_W'(next_r);
        alu_req.b   = ALU_W'(start_r);
        alu_req.sub = 1'b1;
      end
      S_BYTE: begin
        alu_req.a = rowaddr_r;
        alu_req.b = ALU_W'(k_r);
      end
      S_WAIT: begin
        alu_req.a = ALU_W'(top_r);
        alu_req.b = ALU_W'(cfg.scale_y);
      end
      S_BOT: begin
        alu_req.a   = ALU_W'(tnext_r);
        alu_req.b   = ALU_W'(1'b1);
        alu_req.sub = 1'b1;
      end
      S_EMIT: begin
        alu_req.a = rowaddr_r;
        alu_req.b = ALU_W'(cfg.row_stride);
      end
      default: alu_req = '0;
    endcase
  end

  // Extract the row mask: align the byte window to the glyph's first bit
  always_comb begin
    win_sh = win_r << start_r[2:0];
    for (int x = 0; x < 32; x++) begin
      mask_c[x] = win_sh[39-x] && (7'(x) < width_r);
    end
  end

  // Byte count per row and last-row flag
  always_comb begin
    rd_w   = (width_r > 7'd32) ? 6'd32 : width_r[5:0];
    nsum   = 7'(start_r[2:0]) + 7'(rd_w) + 7'd7;
    last_c = (6'(row_r) + 6'd1) == height_r;
    byte_c = pend_oob_r ? 8'd0 : st_rdata;
  end

  // Sequencer next state
  always_comb begin
    state_nxt    = state_r;
    code_nxt     = code_r;
    x_nxt        = x_r;
    top_nxt      = top_r;
    tnext_nxt    = tnext_r;
    bot_nxt      = bot_r;
    idx_nxt      = idx_r;
    oor_nxt      = oor_r;
    start_nxt    = start_r;
    next_nxt     = next_r;
    width_nxt    = width_r;
    nbytes_nxt   = nbytes_r;
    height_nxt   = height_r;
    row_nxt      = row_r;
    rowaddr_nxt  = rowaddr_r;
    k_nxt        = k_r;
    pend_nxt     = 1'b0;
    pend_k_nxt   = pend_k_r;
    pend_oob_nxt = pend_oob_r;
    win_nxt      = win_r;
    ov_nxt       = ov_r && out_stall;
    o_row_nxt    = o_row_r;
    o_top_nxt    = o_top_r;
    o_bot_nxt    = o_bot_r;
    o_x_nxt      = o_x_r;
    o_mask_nxt   = o_mask_r;
    o_width_nxt  = o_width_r;
    o_last_nxt   = o_last_r;

    // drop the pending strike byte into its window slot
    if (pend_r) begin
      case (pend_k_r)
        3'd0:    win_nxt[39:32] = byte_c;
        3'd1:    win_nxt[31:24] = byte_c;
        3'd2:    win_nxt[23:16] = byte_c;
        3'd3:    win_nxt[15:8]  = byte_c;
        3'd4:    win_nxt[7:0]   = byte_c;
        default: win_nxt = win_r;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_kind == KIND_DRAW)) begin
          code_nxt  = in_char_code;
          x_nxt     = in_x_origin;
          top_nxt   = in_y_origin;
          state_nxt = S_CHK_LO;
        end
      end
      S_CHK_LO: begin
        idx_nxt   = alu_rsp.sum[13:0];
        state_nxt = alu_rsp.carry ? S_CHK_HI : S_IDLE;
      end
      S_CHK_HI: begin
        state_nxt = alu_rsp.carry ? S_OFS0 : S_IDLE;
      end
      S_OFS0: begin
        oor_nxt   = (idx_r >= OFS_LIM);
        idx_nxt   = alu_rsp.sum[13:0];
        state_nxt = S_OFS1;
      end
      S_OFS1: begin
        start_nxt = oor_r ? 16'd0 : of_rdata;
        oor_nxt   = (idx_r >= OFS_LIM);
        state_nxt = S_OFS2;
      end
      S_OFS2: begin
        next_nxt  = oor_r ? 16'd0 : of_rdata;
        state_nxt = S_WID;
      end
      S_WID: begin
        if (!alu_rsp.carry) begin
          width_nxt = 7'd0;
        end else if (alu_rsp.sum[15:0] > 16'(MAXW_SAT)) begin
          width_nxt = 7'(MAXW_SAT);
        end else begin
          width_nxt = alu_rsp.sum[6:0];
        end
        state_nxt = S_SETUP;
      end
      S_SETUP: begin
        nbytes_nxt  = (nsum[5:3] == 3'd0) ? 3'd1 : nsum[5:3];
        height_nxt  = (cfg.glyph_height > 6'(HCAP)) ? 6'(HCAP) : cfg.glyph_height;
        rowaddr_nxt = ALU_W'(start_r[15:3]);
        row_nxt     = 5'd0;
        k_nxt       = 3'd0;
        state_nxt   = (cfg.glyph_height == 6'd0) ? S_IDLE : S_BYTE;
      end
      S_BYTE: begin
        pend_nxt     = 1'b1;
        pend_k_nxt   = k_r;
        pend_oob_nxt = (alu_rsp.sum >= STRIKE_LIM);
        k_nxt        = k_r + 3'd1;
        if (k_r == (nbytes_r - 3'd1)) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        tnext_nxt = alu_rsp.sum[15:0];
        state_nxt = S_BOT;
      end
      S_BOT: begin
        bot_nxt   = alu_rsp.sum[15:0];
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          ov_nxt      = 1'b1;
          o_row_nxt   = row_r;
          o_top_nxt   = top_r;
          o_bot_nxt   = bot_r;
          o_x_nxt     = x_r;
          o_mask_nxt  = mask_c;
          o_width_nxt = width_r[5:0];
          o_last_nxt  = last_c;
          rowaddr_nxt = alu_rsp.sum;
          top_nxt     = tnext_r;
          row_nxt     = row_r + 5'd1;
          k_nxt       = 3'd0;
          state_nxt   = last_c ? S_IDLE : S_BYTE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
    code_r     <= code_nxt;
    x_r        <= x_nxt;
    top_r      <= top_nxt;
    tnext_r    <= tnext_nxt;
    bot_r      <= bot_nxt;
    idx_r      <= idx_nxt;
    oor_r      <= oor_nxt;
    start_r    <= start_nxt;
    next_r     <= next_nxt;
    width_r    <= width_nxt;
    nbytes_r   <= nbytes_nxt;
    height_r   <= height_nxt;
    row_r      <= row_nxt;
    rowaddr_r  <= rowaddr_nxt;
    k_r        <= k_nxt;
    pend_k_r   <= pend_k_nxt;
    pend_oob_r <= pend_oob_nxt;
    win_r      <= win_nxt;
    o_row_r    <= o_row_nxt;
    o_top_r    <= o_top_nxt;
    o_bot_r    <= o_bot_nxt;
    o_x_r      <= o_x_nxt;
    o_mask_r   <= o_mask_nxt;
    o_width_r  <= o_width_nxt;
    o_last_r   <= o_last_nxt;
  end

endmodule

### rtl/font_strike_glyph_rows_top.sv
// Font strike glyph row renderer. Load items (strike byte or offset entry) and
// items of the unused kind leave the block idle, and the block takes the next item
// at once. A draw item whose code is out of range stalls the input while its code
// is compared with first_code and, if that passes, last_code. A draw item whose
// code is in range stalls it through the lookup (both range compares, two offset
// reads, width and setup), then per glyph row through one strike byte read for
// each of the n = 1..5 strike bytes the row spans, the next row top, the row
// bottom and the emit. A glyph height of zero costs the lookup only. The single
// read port of the strike RAM, one byte per cycle, and the one shared adder that
// forms the read addresses, the code range compares and the row coordinates set
// the pace. A stall on the result side pauses the walk. Draw items are not taken
// while a glyph is being walked.
// Depends on fsgr_pkg, fsgr_ram, fsgr_cfg, fsgr_core.
module font_strike_glyph_rows_top
  import fsgr_pkg::*;
#(
  parameter int STRIKE_BYTES   = 16384,
  parameter int OFFSET_ENTRIES = 512,
  parameter int MAX_WIDTH      = 32,
  parameter int MAX_HEIGHT     = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input item channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic [13:0]        in_load_address,
  input  logic [15:0]        in_load_value,
  input  logic [12:0]        in_char_code,
  input  logic signed [15:0] in_x_origin,
  input  logic signed [15:0] in_y_origin,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         out_row_index,
  output logic signed [15:0] out_row_top,
  output logic signed [15:0] out_row_bottom,
  output logic signed [15:0] out_x_left,
  output logic [31:0]        out_pixel_mask,
  output logic [5:0]         out_glyph_width,
  output logic               out_last_row
);

  localparam int SAW = $clog2(STRIKE_BYTES);
  localparam int OAW = $clog2(OFFSET_ENTRIES);

  cfg_t           cfg;
  logic           st_we;
  logic [SAW-1:0] st_waddr;
  logic [7:0]     st_wdata;
  logic [SAW-1:0] st_raddr;
  logic [7:0]     st_rdata;
  logic           of_we;
  logic [OAW-1:0] of_waddr;
  logic [15:0]    of_wdata;
  logic [OAW-1:0] of_raddr;
  logic [15:0]    of_rdata;

  fsgr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Packed strike bytes
  fsgr_ram #(.WIDTH(8), .DEPTH(STRIKE_BYTES)) u_strike_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // Glyph bit offsets
  fsgr_ram #(.WIDTH(16), .DEPTH(OFFSET_ENTRIES)) u_offset_ram (
    .clk   (clk),
    .we    (of_we),
    .waddr (of_waddr),
    .wdata (of_wdata),
    .raddr (of_raddr),
    .rdata (of_rdata)
  );

  fsgr_core #(
    .STRIKE_BYTES   (STRIKE_BYTES),
    .OFFSET_ENTRIES (OFFSET_ENTRIES),
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_HEIGHT     (MAX_HEIGHT)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_load_address (in_load_address),
    .in_load_value   (in_load_value),
    .in_char_code    (in_char_code),
    .in_x_origin     (in_x_origin),
    .in_y_origin     (in_y_origin),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_index   (out_row_index),
    .out_row_top     (out_row_top),
    .out_row_bottom  (out_row_bottom),
    .out_x_left      (out_x_left),
    .out_pixel_mask  (out_pixel_mask),
    .out_glyph_width (out_glyph_width),
    .out_last_row    (out_last_row),
    .st_we           (st_we),
    .st_waddr        (st_waddr),
    .st_wdata        (st_wdata),
    .st_raddr        (st_raddr),
    .st_rdata        (st_rdata),
    .of_we           (of_we),
    .of_waddr        (of_waddr),
    .of_wdata        (of_wdata),
    .of_raddr        (of_raddr),
    .of_rdata        (of_rdata)
  );

endmodule

### rtl/fsgr_chk.sv
// Port-level checker for the glyph row renderer, bound to the top level.
// Depends on fsgr_pkg and font_strike_glyph_rows_top.
module fsgr_chk
  import fsgr_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         in_kind,
  input logic               out_valid,
  input logic               out_stall,
  input logic [4:0]         out_row_index,
  input logic signed [15:0] out_row_top,
  input logic [31:0]        out_pixel_mask,
  input logic [5:0]         out_glyph_width,
  input logic               out_last_row
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_mask)
      && $stable(out_row_top) && $stable(out_row_index))
    else $error("stalled result changed");

  // A taken draw item blocks the input channel next cycle
  a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_kind == KIND_DRAW) |=> in_stall)
    else $error("draw item did not stall the input");

  // While a glyph still has rows to come, no item is taken
  a_glyph_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_row |-> in_stall)
    else $error("input open in the middle of a glyph");

  // No pixel is set at or beyond the glyph width
  a_mask_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_glyph_width != 6'd0) && (out_glyph_width < 6'd32)
      |-> (out_pixel_mask >> out_glyph_width) == 32'd0)
    else $error("pixel set beyond glyph width");

endmodule

bind font_strike_glyph_rows_top fsgr_chk u_fsgr_chk (.*);

### tb/tb_font_strike_glyph_rows_top.sv
// Testbench for the font strike glyph row renderer: loads strike bytes and offset
// entries, draws glyphs under several register settings and checks every row result.
// Depends on fsgr_pkg and font_strike_glyph_rows_top.
module tb_font_strike_glyph_rows_top;
  import fsgr_pkg::*;

  localparam int STRIKE_BYTES   = 16384;
  localparam int OFFSET_ENTRIES = 512;
  localparam int SAW            = $clog2(STRIKE_BYTES);
  localparam int OAW            = $clog2(OFFSET_ENTRIES);
  localparam int MAX_WIDTH      = 32;
  localparam int MAX_HEIGHT     = 32;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int SETTLE_CYCLES  = 300;
  localparam int IDLE_PCT       = 35;
  localparam int PHASES         = 9;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [13:0] load_address;
    logic [15:0] load_value;
    logic [12:0] char_code;
    logic [15:0] x_origin;
    logic [15:0] y_origin;
  } glyph_req_t;

  typedef struct packed {
    logic [4:0]  row_index;
    logic [15:0] row_top;
    logic [15:0] row_bottom;
    logic [15:0] x_left;
    logic [31:0] pixel_mask;
    logic [5:0]  glyph_width;
    logic        last_row;
  } glyph_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_kind = '0;
  logic [13:0]        in_load_address = '0;
  logic [15:0]        in_load_value = '0;
  logic [12:0]        in_char_code = '0;
  logic signed [15:0] in_x_origin = '0;
  logic signed [15:0] in_y_origin = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [4:0]         out_row_index;
  logic signed [15:0] out_row_top;
  logic signed [15:0] out_row_bottom;
  logic signed [15:0] out_x_left;
  logic [31:0]        out_pixel_mask;
  logic [5:0]         out_glyph_width;
  logic               out_last_row;

  font_strike_glyph_rows_top dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_load_address(in_load_address), .in_load_value(in_load_value),
    .in_char_code(in_char_code), .in_x_origin(in_x_origin), .in_y_origin(in_y_origin),
    .out_valid(out_valid), .out_stall(out_stall), .out_row_index(out_row_index),
    .out_row_top(out_row_top), .out_row_bottom(out_row_bottom), .out_x_left(out_x_left),
    .out_pixel_mask(out_pixel_mask), .out_glyph_width(out_glyph_width),
    .out_last_row(out_last_row)
  );

  always #4 clk = ~clk;

  // Items waiting for the driver and rows waiting for the block
  glyph_req_t item_backlog[$];
  glyph_row_t pending_rows[$];

  // Font state as the block holds it, updated when an item is taken
  cfg_t       font_cfg;
  logic [7:0]  strike_copy [STRIKE_BYTES];
  logic [15:0] offset_copy [OFFSET_ENTRIES];

  // Font state as it will be once the backlog drains, used to plan loads
  bit          strike_planned [STRIKE_BYTES];
  bit          offset_planned [OFFSET_ENTRIES];
  logic [15:0] offset_plan [OFFSET_ENTRIES];

  int fail_count = 0;
  int cycle_count = 0;
  bit in_taken = 1'b0;
  bit calm = 1'b0;

  // Glyph width: offset difference, zero when negative, saturated
  function automatic int glyph_cols(input int start, input int next);
    int w;
    w = (next > start) ? next - start : 0;
    return (w > MAX_WIDTH) ? MAX_WIDTH : w;
  endfunction

  function automatic int glyph_rows(input logic [5:0] height);
    return (int'(height) > MAX_HEIGHT) ? MAX_HEIGHT : int'(height);
  endfunction

  // Apply one taken item to the font copy and queue the rows it draws
  task automatic render_rows(input glyph_req_t it);
    int idx, start, next, cols, rows, base, addr, pos, y, x;
    logic [31:0] mask;
    glyph_row_t row;
    case (it.kind)
      KIND_STRIKE: strike_copy[it.load_address] = it.load_value[7:0];
      KIND_OFFSET: begin
        if (int'(it.load_address) < OFFSET_ENTRIES)
          offset_copy[OAW'(it.load_address)] = it.load_value;
      end
      KIND_DRAW: begin
        if (it.char_code >= font_cfg.first_code && it.char_code <= font_cfg.last_code) begin
          idx = int'(it.char_code) - int'(font_cfg.first_code);
          start = (idx < OFFSET_ENTRIES) ? int'(offset_copy[OAW'(idx)]) : 0;
          next = (idx + 1 < OFFSET_ENTRIES) ? int'(offset_copy[OAW'(idx + 1)]) : 0;
          cols = glyph_cols(start, next);
          rows = glyph_rows(font_cfg.glyph_height);
          base = start >> 3;
          for (y = 0; y < rows; y++) begin
            mask = '0;
            for (x = 0; x < cols; x++) begin
              pos = (start & 7) + x;
              addr = base + y * int'(font_cfg.row_stride) + (pos >> 3);
              if (addr < STRIKE_BYTES && strike_copy[SAW'(addr)][3'(7 - (pos & 7))])
                mask[5'(x)] = 1'b1;
            end
            row.row_index = 5'(y);
            row.row_top = 16'(int'(it.y_origin) + y * int'(font_cfg.scale_y));
            row.row_bottom = 16'(int'(row.row_top) + int'(font_cfg.scale_y) - 1);
            row.x_left = it.x_origin;
            row.pixel_mask = mask;
            row.glyph_width = 6'(cols);
            row.last_row = (y + 1 == rows);
            pending_rows.push_back(row);
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic glyph_req_t noise_item(input logic [1:0] kind);
    glyph_req_t it;
    it.kind = kind;
    it.load_address = 14'($urandom);
    it.load_value = 16'($urandom);
    it.char_code = 13'($urandom);
    it.x_origin = 16'($urandom);
    it.y_origin = 16'($urandom);
    return it;
  endfunction

  task automatic post_item(input glyph_req_t it);
    if (it.kind == KIND_STRIKE) strike_planned[it.load_address] = 1'b1;
    if (it.kind == KIND_OFFSET && int'(it.load_address) < OFFSET_ENTRIES) begin
      offset_planned[OAW'(it.load_address)] = 1'b1;
      offset_plan[OAW'(it.load_address)] = it.load_value;
    end
    item_backlog.push_back(it);
  endtask

  task automatic post_load(input logic [1:0] kind, input int addr, input int value);
    glyph_req_t it;
    it = noise_item(kind);
    it.load_address = 14'(addr);
    it.load_value = 16'(value);
    post_item(it);
  endtask

  // Queue a draw, first loading every entry it reads that was never written
  task automatic post_draw(input int code, input int xo, input int yo);
    glyph_req_t it;
    int idx, k, start, next, span, y, b, addr;
    it = noise_item(KIND_DRAW);
    it.char_code = 13'(code);
    it.x_origin = 16'(xo);
    it.y_origin = 16'(yo);
    if (it.char_code >= font_cfg.first_code && it.char_code <= font_cfg.last_code) begin
      idx = int'(it.char_code) - int'(font_cfg.first_code);
      for (k = idx; k <= idx + 1; k++) begin
        if (k < OFFSET_ENTRIES && !offset_planned[OAW'(k)])
          post_load(KIND_OFFSET, k, $urandom_range(65535));
      end
      start = (idx < OFFSET_ENTRIES) ? int'(offset_plan[OAW'(idx)]) : 0;
      next = (idx + 1 < OFFSET_ENTRIES) ? int'(offset_plan[OAW'(idx + 1)]) : 0;
      span = ((start & 7) + glyph_cols(start, next) + 7) >> 3;
      if (span < 1) span = 1;
      for (y = 0; y < glyph_rows(font_cfg.glyph_height); y++) begin
        for (b = 0; b < span; b++) begin
          addr = (start >> 3) + y * int'(font_cfg.row_stride) + b;
          if (addr < STRIKE_BYTES && !strike_planned[SAW'(addr)])
            post_load(KIND_STRIKE, addr, $urandom);
        end
      end
    end
    post_item(it);
  endtask

  // Mostly in-range draws near the table start, plus stray codes, loads and unused kinds
  task automatic post_random_item();
    int pick, span, idx;
    pick = $urandom_range(99);
    if (pick < 66 && font_cfg.first_code <= font_cfg.last_code) begin
      span = int'(font_cfg.last_code) - int'(font_cfg.first_code);
      idx = ($urandom_range(9) == 0) ? $urandom_range(span) :
            $urandom_range((span < 63) ? span : 63);
      post_draw(int'(font_cfg.first_code) + idx, $urandom, $urandom);
    end else if (pick < 76) begin
      post_draw($urandom, $urandom, $urandom);
    end else if (pick < 84) begin
      post_load(KIND_OFFSET, $urandom_range(1) ? $urandom_range(64) : $urandom_range(16383),
                ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(700));
    end else if (pick < 92) begin
      post_load(KIND_STRIKE, $urandom, $urandom);
    end else begin
      post_item(noise_item(KIND_UNUSED));
    end
  endtask

  // Register write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [2:0] index, input int value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (index)
      REG_FIRST_CODE:   font_cfg.first_code = 13'(value);
      REG_LAST_CODE:    font_cfg.last_code = 13'(value);
      REG_ROW_STRIDE:   font_cfg.row_stride = 11'(value);
      REG_GLYPH_HEIGHT: font_cfg.glyph_height = 6'(value);
      REG_SCALE_X:      font_cfg.scale_x = 7'(value);
      REG_SCALE_Y:      font_cfg.scale_y = 7'(value);
      default: ;
    endcase
  endtask

  task automatic set_font(input int first, input int last, input int stride,
                          input int height, input int sx, input int sy);
    write_reg(REG_FIRST_CODE, first);
    write_reg(REG_LAST_CODE, last);
    write_reg(REG_ROW_STRIDE, stride);
    write_reg(REG_GLYPH_HEIGHT, height);
    write_reg(REG_SCALE_X, sx);
    write_reg(REG_SCALE_Y, sy);
  endtask

  // Wait until every item is taken and every row has come, then let the block settle
  task automatic wait_idle();
    do @(posedge clk); while (item_backlog.size() != 0 || in_valid || pending_rows.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic report_row(input string what, input glyph_row_t want, input glyph_row_t got);
    $display("%0t: %s: expected row=%0d top=%0d bottom=%0d x=%0d mask=%h width=%0d last=%0b",
             $time, what, want.row_index, $signed(want.row_top), $signed(want.row_bottom),
             $signed(want.x_left), want.pixel_mask, want.glyph_width, want.last_row,
             "\n    actual row=%0d top=%0d bottom=%0d x=%0d mask=%h width=%0d last=%0b",
             got.row_index, $signed(got.row_top), $signed(got.row_bottom),
             $signed(got.x_left), got.pixel_mask, got.glyph_width, got.last_row);
  endtask

  // Drive items: hold while stalled, otherwise present the next one or idle
  always @(negedge clk) begin : drive_items
    glyph_req_t it;
    if (!in_valid || in_taken) begin
      if (item_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        it = item_backlog.pop_front();
        in_kind <= it.kind;
        in_load_address <= it.load_address;
        in_load_value <= it.load_value;
        in_char_code <= it.char_code;
        in_x_origin <= it.x_origin;
        in_y_origin <= it.y_origin;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result side at random
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Take items into the font copy and check each row against the oldest one due
  always @(posedge clk) begin : watch_rows
    glyph_row_t got, want;
    in_taken <= in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall)
        render_rows({in_kind, in_load_address, in_load_value, in_char_code,
                     in_x_origin, in_y_origin});
      if (out_valid && !out_stall) begin
        got = {out_row_index, out_row_top, out_row_bottom, out_x_left,
               out_pixel_mask, out_glyph_width, out_last_row};
        if (pending_rows.size() == 0) begin
          fail_count++;
          report_row("row with none due", '0, got);
        end else begin
          want = pending_rows.pop_front();
          if (got !== want) begin
            fail_count++;
            report_row("row mismatch", want, got);
          end
        end
      end
    end
  end

  // Hard stop on a hung block
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : run_font
    int i, phase, n, acc, first, last;
    // The block loads its config reset values at reset; the store copies start at zero
    foreach (strike_copy[j]) strike_copy[j] = '0;
    foreach (offset_copy[j]) offset_copy[j] = '0;
    font_cfg.first_code = 13'd0;
    font_cfg.last_code = 13'd255;
    font_cfg.row_stride = 11'd256;
    font_cfg.glyph_height = 6'd16;
    font_cfg.scale_x = 7'd3;
    font_cfg.scale_y = 7'd3;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: aligned, unaligned, empty, negative and saturated widths
    post_load(KIND_OFFSET, 0, 0);
    post_load(KIND_OFFSET, 1, 8);
    post_load(KIND_OFFSET, 2, 13);
    post_load(KIND_OFFSET, 3, 13);
    post_load(KIND_OFFSET, 4, 5);
    post_load(KIND_OFFSET, 5, 45);
    post_load(KIND_OFFSET, 6, 65528);
    post_load(KIND_OFFSET, 7, 65535);
    post_load(KIND_OFFSET, 511, 16);
    post_draw(0, 0, 0);
    post_draw(1, -32768, 32767);
    post_draw(2, 32767, -32768);
    post_draw(3, -1, -1);
    post_draw(4, 100, 32760);
    post_draw(5, -200, 7);
    post_draw(6, 1, -3);
    // Codes past last_code give nothing, also around a load beyond the table
    post_draw(511, 12, 34);
    post_draw(600, -12, -34);
    post_load(KIND_OFFSET, 600, 65535);
    post_draw(600, 5, 5);
    post_load(KIND_STRIKE, 16383, 'hAB5A);
    post_item(noise_item(KIND_UNUSED));
    post_draw(256, 0, 0);
    wait_idle();

    for (phase = 1; phase < PHASES; phase++) begin
      calm = (phase == 1);
      case (phase)
        1: set_font(0, 8191, 1, 32, 1, 1);
        2: set_font(0, 8191, 0, 0, 0, 0);
        3: set_font(8000, 8191, 2047, 63, 127, 127);
        4: set_font(4000, 3999, 300, 4, 64, 64);
        5: set_font(7, 70, 17, 3, 0, 0);
        default: begin
          first = $urandom_range(1) ? $urandom_range(300) : $urandom_range(8191);
          last = ($urandom_range(4) == 0) ? $urandom_range(8191) : first + $urandom_range(400);
          if (last > 8191) last = 8191;
          set_font(first, last, $urandom_range(2047),
                   ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(8, 1),
                   $urandom_range(127), $urandom_range(127));
        end
      endcase
      // Lay out a packed table of mostly narrow glyphs
      if (phase == 1) begin
        acc = $urandom_range(7);
        for (i = 0; i <= 64; i++) begin
          post_load(KIND_OFFSET, i, acc);
          acc += ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(12);
        end
      end
      for (n = 0; n < ((phase == 1) ? 30 : (phase == 2 || phase == 4) ? 8 : 16); n++)
        post_random_item();
      wait_idle();
    end

    if (fail_count == 0 && pending_rows.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
